>>> hdl/assert_macros.svh
// assertion macros shared by the model matrix composer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition never holds
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hdl/mmc_pkg.sv
// types and constants shared by the model matrix composer
package mmc_pkg;

	// trig arithmetic
	localparam int TRIG_BITS = 30;
	localparam int ONE_Q30 = 1 << TRIG_BITS;
	localparam int G_W = 12;
	localparam int TURN_W = 17;
	localparam logic [TURN_W-1:0] FULL_TURN = 17'd23040;
	localparam logic [TURN_W-1:0] QUARTER_TURN = 17'd5760;
	localparam logic [TURN_W-1:0] EIGHTH_TURN = 17'd2880;
	localparam logic [TURN_W-1:0] TURN_BIAS = 17'd46080;

	// degrees to radians: x = round(g * PI_Q30 / X_DIV)
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint unsigned X_DIV = 64'd11520;
	localparam int X_SHIFT = 20;
	localparam longint unsigned X_RECIP = (PI_Q30 << X_SHIFT) / X_DIV;

	// horner steps: sine terms first, then cosine terms
	localparam int NUM_STEPS = 11;
	localparam logic [3:0] SIN_LAST = 4'd4;
	localparam logic [3:0] COS_LAST = 4'd10;
	localparam logic [7:0] STEP_DIV [NUM_STEPS] = '{
		8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
		8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [29:0] STEP_RECIP [NUM_STEPS] = '{
		30'(ONE_Q30 / 110), 30'(ONE_Q30 / 72), 30'(ONE_Q30 / 42),
		30'(ONE_Q30 / 20), 30'(ONE_Q30 / 6), 30'(ONE_Q30 / 132),
		30'(ONE_Q30 / 90), 30'(ONE_Q30 / 56), 30'(ONE_Q30 / 30),
		30'(ONE_Q30 / 12), 30'(ONE_Q30 / 2)};

	// composition order
	localparam logic [1:0] MODE_TRS = 2'd0;
	localparam logic [1:0] MODE_RTS = 2'd1;
	localparam logic [1:0] MODE_STR = 2'd2;

	localparam logic [1:0] ROW_LAST = 2'd3;

	// angle split into quadrant, octant fold and folded offset
	typedef struct packed {
		logic [1:0] quad;
		logic swap;
		logic [G_W-1:0] g;
	} ang_class_t;

	// one queued transform
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		ang_class_t ang_x;
		ang_class_t ang_y;
		ang_class_t ang_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} item_t;

endpackage

>>> hdl/mmc_front.sv
// front end: accepts a transform and folds its angles into octant form
module mmc_front (
	input logic start,
	input logic busy,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [15:0] rot_x,
	input logic signed [15:0] rot_y,
	input logic signed [15:0] rot_z,
	input logic signed [31:0] scale_x,
	input logic signed [31:0] scale_y,
	input logic signed [31:0] scale_z,
	output logic push,
	output mmc_pkg::item_t item
);

	// reduce modulo one turn, then split into quadrant and folded offset
	function automatic mmc_pkg::ang_class_t classify(input logic signed [15:0] ang);
		logic [mmc_pkg::TURN_W-1:0] v;
		logic [mmc_pkg::TURN_W-1:0] r;
		logic [mmc_pkg::TURN_W-1:0] f;
		logic [mmc_pkg::TURN_W-1:0] g;
		mmc_pkg::ang_class_t c;
		v = {ang[15], ang} + mmc_pkg::TURN_BIAS;
		if (v >= mmc_pkg::TURN_W'(3 * mmc_pkg::FULL_TURN)) begin
			r = v - mmc_pkg::TURN_W'(3 * mmc_pkg::FULL_TURN);
		end else if (v >= mmc_pkg::TURN_W'(2 * mmc_pkg::FULL_TURN)) begin
			r = v - mmc_pkg::TURN_W'(2 * mmc_pkg::FULL_TURN);
		end else if (v >= mmc_pkg::FULL_TURN) begin
			r = v - mmc_pkg::FULL_TURN;
		end else begin
			r = v;
		end
		if (r >= mmc_pkg::TURN_W'(3 * mmc_pkg::QUARTER_TURN)) begin
			c.quad = 2'd3;
			f = r - mmc_pkg::TURN_W'(3 * mmc_pkg::QUARTER_TURN);
		end else if (r >= mmc_pkg::TURN_W'(2 * mmc_pkg::QUARTER_TURN)) begin
			c.quad = 2'd2;
			f = r - mmc_pkg::TURN_W'(2 * mmc_pkg::QUARTER_TURN);
		end else if (r >= mmc_pkg::QUARTER_TURN) begin
			c.quad = 2'd1;
			f = r - mmc_pkg::QUARTER_TURN;
		end else begin
			c.quad = 2'd0;
			f = r;
		end
		c.swap = f > mmc_pkg::EIGHTH_TURN;
		g = c.swap ? mmc_pkg::QUARTER_TURN - f : f;
		c.g = g[mmc_pkg::G_W-1:0];
		return c;
	endfunction

	// transaction accepted while the queue has room
	assign push = start && !busy;

	always_comb begin
		item.pos_x = pos_x;
		item.pos_y = pos_y;
		item.pos_z = pos_z;
		item.ang_x = classify(rot_x);
		item.ang_y = classify(rot_y);
		item.ang_z = classify(rot_z);
		item.scale_x = scale_x;
		item.scale_y = scale_y;
		item.scale_z = scale_z;
	end

endmodule

>>> hdl/mmc_queue.sv
// two-entry queue between front end and back end
module mmc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mmc_pkg::item_t item_in,
	input logic pop,
	output logic full,
	output logic not_empty,
	output mmc_pkg::item_t item_out
);

	mmc_pkg::item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign item_out = slot_q[rd_ptr_q];

endmodule

>>> hdl/mmc_trig.sv
// sine and cosine of one folded angle by iterated taylor series in q30
module mmc_trig #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input mmc_pkg::ang_class_t ang,
	output logic done,
	output logic signed [FRAC_BITS+1:0] sin_val,
	output logic signed [FRAC_BITS+1:0] cos_val
);

	localparam int TW = FRAC_BITS + 2;
	localparam int MW = FRAC_BITS + 1;
	localparam int RND_SH = mmc_pkg::TRIG_BITS - FRAC_BITS;
	localparam logic [31:0] RND_HALF = 32'(1) << (RND_SH - 1);
	localparam logic [30:0] ONE = 31'(mmc_pkg::ONE_Q30);
	localparam logic [50:0] EST_HALF = 51'(1) << (mmc_pkg::X_SHIFT - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_XEST = 4'd1;
	localparam logic [3:0] ST_XFIX = 4'd2;
	localparam logic [3:0] ST_SQ = 4'd3;
	localparam logic [3:0] ST_INIT = 4'd4;
	localparam logic [3:0] ST_MUL = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_FIX = 4'd7;
	localparam logic [3:0] ST_SM = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] step_q;
	logic done_q;
	logic [1:0] quad_q;
	logic swap_q;
	logic [mmc_pkg::G_W-1:0] g_q;
	logic [43:0] full_q;
	logic [29:0] est_q;
	logic [29:0] x_q;
	logic [59:0] sq_q;
	logic [29:0] x2_q;
	logic [30:0] ts_q;
	logic [60:0] prod_q;
	logic [30:0] v_q;
	logic [30:0] qe_q;
	logic [30:0] sm_q;
	logic signed [TW-1:0] sin_q;
	logic signed [TW-1:0] cos_q;

	logic [43:0] full_d;
	logic [50:0] est_full;
	logic [43:0] rem;
	logic [30:0] v_d;
	logic [61:0] qe_full;
	logic [38:0] qd;
	logic [38:0] r_fix;
	logic [30:0] qc;
	logic [61:0] sm_full;
	logic [30:0] so;
	logic [30:0] co;
	logic [MW-1:0] so_m;
	logic [MW-1:0] co_m;
	logic signed [TW-1:0] so_p;
	logic signed [TW-1:0] co_p;

	// datapath terms of each phase
	always_comb begin
		full_d = 44'(g_q) * 44'(mmc_pkg::PI_Q30) + 44'(mmc_pkg::X_DIV / 2);
		est_full = 51'(g_q) * 51'(mmc_pkg::X_RECIP) + EST_HALF;
		rem = full_q - 44'(est_q) * 44'(mmc_pkg::X_DIV);
		v_d = prod_q[60:30];
		qe_full = 62'(v_d) * 62'(mmc_pkg::STEP_RECIP[step_q]);
		qd = 39'(qe_q) * 39'(mmc_pkg::STEP_DIV[step_q]);
		r_fix = 39'(v_q) - qd;
		qc = qe_q + 31'(r_fix >= 39'(mmc_pkg::STEP_DIV[step_q]));
		sm_full = 62'(x_q) * 62'(ts_q) + (62'(1) << 29);
		so = swap_q ? ts_q : sm_q;
		co = swap_q ? sm_q : ts_q;
		so_m = MW'((32'(so) + RND_HALF) >> RND_SH);
		co_m = MW'((32'(co) + RND_HALF) >> RND_SH);
		so_p = $signed({1'b0, so_m});
		co_p = $signed({1'b0, co_m});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_XEST;
					end
				end
				ST_XEST: state_q <= ST_XFIX;
				ST_XFIX: state_q <= ST_SQ;
				ST_SQ: state_q <= ST_INIT;
				ST_INIT: begin
					step_q <= 4'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_FIX;
				ST_FIX: begin
					step_q <= step_q + 4'd1;
					if (step_q == mmc_pkg::SIN_LAST) begin
						state_q <= ST_SM;
					end else if (step_q == mmc_pkg::COS_LAST) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SM: state_q <= ST_MUL;
				ST_OUT: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quad_q <= ang.quad;
				swap_q <= ang.swap;
				g_q <= ang.g;
			end
			ST_XEST: begin
				full_q <= full_d;
				est_q <= est_full[mmc_pkg::X_SHIFT+29:mmc_pkg::X_SHIFT];
			end
			ST_XFIX: x_q <= est_q + 30'(rem >= 44'(mmc_pkg::X_DIV));
			ST_SQ: sq_q <= 60'(x_q) * 60'(x_q);
			ST_INIT: begin
				x2_q <= 30'((sq_q + (60'(1) << 29)) >> 30);
				ts_q <= ONE;
			end
			ST_MUL: prod_q <= 61'(x2_q) * 61'(ts_q);
			ST_DIV: begin
				v_q <= v_d;
				qe_q <= qe_full[60:30];
			end
			ST_FIX: ts_q <= ONE - qc;
			ST_SM: begin
				sm_q <= sm_full[60:30];
				ts_q <= ONE;
			end
			ST_OUT: begin
				case (quad_q)
					2'd0: begin
						sin_q <= so_p;
						cos_q <= co_p;
					end
					2'd1: begin
						sin_q <= co_p;
						cos_q <= -so_p;
					end
					2'd2: begin
						sin_q <= -so_p;
						cos_q <= -co_p;
					end
					default: begin
						sin_q <= -co_p;
						cos_q <= so_p;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

>>> hdl/mmc_back.sv
// back end: trig lanes, rotation build and row-by-row matrix composition
module mmc_back #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic not_empty,
	input mmc_pkg::item_t item,
	input logic [1:0] mode,
	output logic pop,
	output logic result_valid,
	output logic [1:0] row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic last_row
);

	localparam int TW = FRAC_BITS + 2;
	localparam int RW = FRAC_BITS + 3;
	localparam int PW = RW + 32;
	localparam int AW = 66;
	localparam logic signed [2*RW-1:0] RHALF = (2*RW)'(1) << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] AHALF = AW'(1) << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] SAT_MAX = AW'(32'h7fffffff);
	localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [31:0] ONE_FX = 32'(1) << FRAC_BITS;

	// fixed-point product rounded half up
	function automatic logic signed [RW-1:0] mulq(input logic signed [RW-1:0] a,
			input logic signed [RW-1:0] b);
		logic signed [2*RW-1:0] p;
		p = (2*RW)'(a) * (2*RW)'(b) + RHALF;
		return RW'(p >>> FRAC_BITS);
	endfunction

	// round a wide sum once and clamp to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] t;
		t = (v + AHALF) >>> FRAC_BITS;
		if (t > SAT_MAX) begin
			t = SAT_MAX;
		end else if (t < SAT_MIN) begin
			t = SAT_MIN;
		end
		return t[31:0];
	endfunction

	logic run_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] sc_q [3];

	logic done_x, done_y, done_z, done;
	logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
	logic signed [RW-1:0] sxe, cxe, sye, cye, sze, cze;

	logic v_s1;
	logic signed [RW-1:0] czsy_s1, szsy_s1, m00_s1, m10_s1, m21_s1, m22_s1;
	logic signed [RW-1:0] szcx_s1, szsx_s1, czcx_s1, czsx_s1, sx_s1, cx_s1, sy_s1;
	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] sc_s1 [3];

	logic v_s2;
	logic signed [RW-1:0] a01_s2, a02_s2, a11_s2, a12_s2;
	logic signed [RW-1:0] m00_s2, m10_s2, m21_s2, m22_s2;
	logic signed [RW-1:0] szcx_s2, szsx_s2, czcx_s2, czsx_s2, sy_s2;
	logic signed [31:0] pos_s2 [3];
	logic signed [31:0] sc_s2 [3];

	logic v_s3;
	logic signed [RW-1:0] rm_s3 [3][3];
	logic signed [31:0] pos_s3 [3];
	logic signed [31:0] sc_s3 [3];

	logic row_run_q;
	logic [1:0] row_q;
	logic [1:0] ridx;

	logic v_s4;
	logic [1:0] row_s4;
	logic signed [PW-1:0] pm_s4 [3];
	logic signed [PW-1:0] pa_s4 [3];
	logic signed [63:0] ps_s4;
	logic signed [31:0] pr_s4;

	logic signed [AW-1:0] sum_rts;

	// take the next transaction once the lanes are free
	assign pop = not_empty && !run_q;
	assign done = done_x && done_y && done_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (pop) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q[0] <= item.pos_x;
			pos_q[1] <= item.pos_y;
			pos_q[2] <= item.pos_z;
			sc_q[0] <= item.scale_x;
			sc_q[1] <= item.scale_y;
			sc_q[2] <= item.scale_z;
		end
	end

	// one sine/cosine lane per axis
	mmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_x (
		.clk(clk), .arst_n(arst_n), .go(pop), .ang(item.ang_x),
		.done(done_x), .sin_val(sx), .cos_val(cx)
	);
	mmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_y (
		.clk(clk), .arst_n(arst_n), .go(pop), .ang(item.ang_y),
		.done(done_y), .sin_val(sy), .cos_val(cy)
	);
	mmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig_z (
		.clk(clk), .arst_n(arst_n), .go(pop), .ang(item.ang_z),
		.done(done_z), .sin_val(sz), .cos_val(cz)
	);

	always_comb begin
		sxe = RW'(sx);
		cxe = RW'(cx);
		sye = RW'(sy);
		cye = RW'(cy);
		sze = RW'(sz);
		cze = RW'(cz);
	end

	// stage valids and row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			row_run_q <= 1'b0;
			row_q <= 2'd0;
			v_s4 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1 <= done;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				row_run_q <= 1'b1;
				row_q <= 2'd0;
			end else if (row_run_q) begin
				row_q <= row_q + 2'd1;
				if (row_q == mmc_pkg::ROW_LAST) begin
					row_run_q <= 1'b0;
				end
			end
			v_s4 <= row_run_q;
			result_valid <= v_s4;
		end
	end

	// first products of the rotation
	always_ff @(posedge clk) begin
		if (done) begin
			czsy_s1 <= mulq(cze, sye);
			szsy_s1 <= mulq(sze, sye);
			m00_s1 <= mulq(cze, cye);
			m10_s1 <= mulq(sze, cye);
			m21_s1 <= mulq(cye, sxe);
			m22_s1 <= mulq(cye, cxe);
			szcx_s1 <= mulq(sze, cxe);
			szsx_s1 <= mulq(sze, sxe);
			czcx_s1 <= mulq(cze, cxe);
			czsx_s1 <= mulq(cze, sxe);
			sx_s1 <= sxe;
			cx_s1 <= cxe;
			sy_s1 <= sye;
			pos_s1 <= pos_q;
			sc_s1 <= sc_q;
		end
	end

	// three-factor terms
	always_ff @(posedge clk) begin
		if (v_s1) begin
			a01_s2 <= mulq(czsy_s1, sx_s1);
			a02_s2 <= mulq(czsy_s1, cx_s1);
			a11_s2 <= mulq(szsy_s1, sx_s1);
			a12_s2 <= mulq(szsy_s1, cx_s1);
			m00_s2 <= m00_s1;
			m10_s2 <= m10_s1;
			m21_s2 <= m21_s1;
			m22_s2 <= m22_s1;
			szcx_s2 <= szcx_s1;
			szsx_s2 <= szsx_s1;
			czcx_s2 <= czcx_s1;
			czsx_s2 <= czsx_s1;
			sy_s2 <= sy_s1;
			pos_s2 <= pos_s1;
			sc_s2 <= sc_s1;
		end
	end

	// rotation matrix entries
	always_ff @(posedge clk) begin
		if (v_s2) begin
			rm_s3[0][0] <= m00_s2;
			rm_s3[0][1] <= a01_s2 - szcx_s2;
			rm_s3[0][2] <= szsx_s2 + a02_s2;
			rm_s3[1][0] <= m10_s2;
			rm_s3[1][1] <= czcx_s2 + a11_s2;
			rm_s3[1][2] <= a12_s2 - czsx_s2;
			rm_s3[2][0] <= -sy_s2;
			rm_s3[2][1] <= m21_s2;
			rm_s3[2][2] <= m22_s2;
			pos_s3 <= pos_s2;
			sc_s3 <= sc_s2;
		end
	end

	// row products, one row per cycle
	assign ridx = (row_q == mmc_pkg::ROW_LAST) ? 2'd0 : row_q;

	always_ff @(posedge clk) begin
		row_s4 <= row_q;
		for (int j = 0; j < 3; j++) begin
			pm_s4[j] <= PW'(rm_s3[ridx][j]) *
				PW'((mode == mmc_pkg::MODE_STR) ? sc_s3[ridx] : sc_s3[j]);
			pa_s4[j] <= PW'(rm_s3[ridx][j]) * PW'(pos_s3[j]);
		end
		ps_s4 <= 64'(sc_s3[ridx]) * 64'(pos_s3[ridx]);
		pr_s4 <= pos_s3[ridx];
	end

	// round, clamp and drive the result
	assign sum_rts = AW'(pa_s4[0]) + AW'(pa_s4[1]) + AW'(pa_s4[2]);

	always_ff @(posedge clk) begin
		row_index <= row_s4;
		last_row <= row_s4 == mmc_pkg::ROW_LAST;
		if (row_s4 == mmc_pkg::ROW_LAST) begin
			col0 <= '0;
			col1 <= '0;
			col2 <= '0;
			col3 <= ONE_FX;
		end else begin
			col0 <= round_sat(AW'(pm_s4[0]));
			col1 <= round_sat(AW'(pm_s4[1]));
			col2 <= round_sat(AW'(pm_s4[2]));
			case (mode)
				mmc_pkg::MODE_TRS: col3 <= pr_s4;
				mmc_pkg::MODE_RTS: col3 <= round_sat(sum_rts);
				default: col3 <= round_sat(AW'(ps_s4));
			endcase
		end
	end

endmodule

>>> hdl/model_matrix_compose.sv
// top level of the model matrix composer
// Takes a position, three euler angles (1/64 degree) and a per-axis scale and
// emits the 4x4 model matrix as four row transactions on consecutive cycles,
// row 0 first; the receiver cannot stall them. A transaction is taken when
// start is high and busy is low; busy rises only when the two-entry queue is
// full. A transform waits in the queue, then passes through the three
// sine/cosine lanes (setup states XEST, XFIX, SQ and INIT, eleven taylor steps
// each through MUL, DIV and FIX, the sine product state SM and the output
// state OUT), then the rotation build stages s1 to s3 and the row composition
// through the row sequencer, stage s4 and the output registers. The lanes take
// the next queue entry only after done has released them, so transforms do not
// overlap in the lanes. The order register takes writes at any time via
// cfg_valid (cfg_ready is always high); codes above 2 are dropped.
`include "assert_macros.svh"

module model_matrix_compose #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [15:0] rot_x,
	input logic signed [15:0] rot_y,
	input logic signed [15:0] rot_z,
	input logic signed [31:0] scale_x,
	input logic signed [31:0] scale_y,
	input logic signed [31:0] scale_z,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_data,
	output logic result_valid,
	output logic [1:0] row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic last_row
);

	logic [1:0] mode_q;
	logic push;
	logic pop;
	logic full;
	logic not_empty;
	mmc_pkg::item_t front_item;
	mmc_pkg::item_t head_item;

	// order register, illegal codes ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mmc_pkg::MODE_TRS;
		end else if (cfg_valid && cfg_ready && cfg_data <= mmc_pkg::MODE_STR) begin
			mode_q <= cfg_data;
		end
	end

	assign busy = full;

	mmc_front u_front (
		.start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.push(push), .item(front_item)
	);

	mmc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item_in(front_item),
		.pop(pop), .full(full), .not_empty(not_empty), .item_out(head_item)
	);

	mmc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.not_empty(not_empty), .item(head_item), .mode(mode_q), .pop(pop),
		.result_valid(result_valid), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3), .last_row(last_row)
	);

	// checks
	`ASSERT_NEVER(a_mode_legal, mode_q > mmc_pkg::MODE_STR, "order mode out of range")
	`ASSERT_IMPL(a_last_flag, result_valid, last_row == (row_index == mmc_pkg::ROW_LAST), "last_row flag disagrees with row index")
	`ASSERT_NEXT(a_rows_follow, result_valid && row_index != mmc_pkg::ROW_LAST, result_valid && row_index == $past(row_index) + 2'd1, "matrix rows not consecutive")
	`ASSERT_NEVER(a_pop_empty, pop && !not_empty, "queue popped while empty")

endmodule

>>> test/model_matrix_compose_tb.sv
// self-checking testbench for the model matrix composer
`timescale 1ns / 100ps

module model_matrix_compose_tb;

	localparam int FRAC = 16;
	localparam int TURN = 23040;
	localparam int QUARTER = 5760;
	localparam int EIGHTH = 2880;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] MODE_BAD = 2'd3;

	// one transform request
	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [15:0] rot [3];
		logic signed [31:0] scl [3];
	} xform_t;

	// one matrix row
	typedef struct {
		logic [1:0] row;
		logic [31:0] col [4];
		logic last;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] rot_x, rot_y, rot_z;
	logic signed [31:0] scale_x, scale_y, scale_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_data;
	logic result_valid;
	logic [1:0] row_index;
	logic signed [31:0] col0, col1, col2, col3;
	logic last_row;

	row_t pending_rows [$];
	logic [1:0] order_mode;
	int mismatches;
	int items_sent;
	int rows_checked;
	int idle_pct;

	model_matrix_compose dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.rot_x(rot_x),
		.rot_y(rot_y),
		.rot_z(rot_z),
		.scale_x(scale_x),
		.scale_y(scale_y),
		.scale_z(scale_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.row_index(row_index),
		.col0(col0),
		.col1(col1),
		.col2(col2),
		.col3(col3),
		.last_row(last_row)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// fixed-point product rounded half up
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint fx_round(input longint v);
		return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > longint'(32'sh7fffffff))
			return 32'h7fffffff;
		if (v < -longint'(64'h80000000))
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint q30_mag(input longint unsigned mag, input bit neg);
		longint unsigned r;
		r = (mag + (64'd1 << (mmc_pkg::TRIG_BITS - FRAC - 1))) >> (mmc_pkg::TRIG_BITS - FRAC);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// sine and cosine of an angle in 1/64 degree
	task automatic sin_cos(input int ang, output longint s, output longint c);
		longint unsigned one, x, x2, ts, tc, so, co;
		int r, q, f, g;
		bit swp;
		one = 64'd1 << mmc_pkg::TRIG_BITS;
		r = ang % TURN;
		if (r < 0)
			r += TURN;
		q = r / QUARTER;
		f = r % QUARTER;
		swp = f > EIGHTH;
		g = swp ? QUARTER - f : f;
		x = (64'(g) * mmc_pkg::PI_Q30 + mmc_pkg::X_DIV / 2) / mmc_pkg::X_DIV;
		x2 = (x * x + (64'd1 << (mmc_pkg::TRIG_BITS - 1))) >> mmc_pkg::TRIG_BITS;
		ts = one;
		for (int i = 0; i <= mmc_pkg::SIN_LAST; i++)
			ts = one - ((x2 * ts) >> mmc_pkg::TRIG_BITS) / 64'(mmc_pkg::STEP_DIV[i]);
		tc = one;
		for (int i = mmc_pkg::SIN_LAST + 1; i <= mmc_pkg::COS_LAST; i++)
			tc = one - ((x2 * tc) >> mmc_pkg::TRIG_BITS) / 64'(mmc_pkg::STEP_DIV[i]);
		ts = (x * ts + (64'd1 << (mmc_pkg::TRIG_BITS - 1))) >> mmc_pkg::TRIG_BITS;
		so = swp ? tc : ts;
		co = swp ? ts : tc;
		case (q)
			0: begin s = q30_mag(so, 0); c = q30_mag(co, 0); end
			1: begin s = q30_mag(co, 0); c = q30_mag(so, 1); end
			2: begin s = q30_mag(so, 1); c = q30_mag(co, 1); end
			default: begin s = q30_mag(co, 1); c = q30_mag(so, 0); end
		endcase
	endtask

	// predict the four rows of one transform under the current order
	task automatic predict_matrix(input xform_t t);
		longint sx, cx, sy, cy, sz, cz, czsy, szsy, acc, e;
		longint rm [3][3];
		row_t r;
		sin_cos(t.rot[0], sx, cx);
		sin_cos(t.rot[1], sy, cy);
		sin_cos(t.rot[2], sz, cz);
		czsy = fx_mul(cz, sy);
		szsy = fx_mul(sz, sy);
		rm[0][0] = fx_mul(cz, cy);
		rm[0][1] = -fx_mul(sz, cx) + fx_mul(czsy, sx);
		rm[0][2] = fx_mul(sz, sx) + fx_mul(czsy, cx);
		rm[1][0] = fx_mul(sz, cy);
		rm[1][1] = fx_mul(cz, cx) + fx_mul(szsy, sx);
		rm[1][2] = -fx_mul(cz, sx) + fx_mul(szsy, cx);
		rm[2][0] = -sy;
		rm[2][1] = fx_mul(cy, sx);
		rm[2][2] = fx_mul(cy, cx);
		for (int i = 0; i < 3; i++) begin
			r.row = 2'(i);
			r.last = 1'b0;
			for (int j = 0; j < 3; j++) begin
				e = (order_mode == mmc_pkg::MODE_STR)
					? fx_round(longint'(t.scl[i]) * rm[i][j])
					: fx_round(rm[i][j] * longint'(t.scl[j]));
				r.col[j] = clamp32(e);
			end
			case (order_mode)
				mmc_pkg::MODE_TRS: e = t.pos[i];
				mmc_pkg::MODE_RTS: begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += rm[i][k] * longint'(t.pos[k]);
					e = fx_round(acc);
				end
				default: e = fx_round(longint'(t.scl[i]) * longint'(t.pos[i]));
			endcase
			r.col[3] = clamp32(e);
			pending_rows.push_back(r);
		end
		r.row = mmc_pkg::ROW_LAST;
		r.last = 1'b1;
		r.col[0] = '0;
		r.col[1] = '0;
		r.col[2] = '0;
		r.col[3] = 32'd1 << FRAC;
		pending_rows.push_back(r);
	endtask

	// row checker
	always @(posedge clk) begin
		row_t want;
		if (arst_n && result_valid) begin
			rows_checked++;
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected row %0d at %0t", row_index, $time);
			end else begin
				want = pending_rows.pop_front();
				if (row_index !== want.row || col0 !== want.col[0] ||
						col1 !== want.col[1] || col2 !== want.col[2] ||
						col3 !== want.col[3] || last_row !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("row mismatch at %0t: exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
							$time, want.row, want.col[0], want.col[1], want.col[2],
							want.col[3], want.last, row_index, col0, col1, col2, col3,
							last_row);
				end
			end
		end
	end

	// send one transform, holding start while the queue is full
	task automatic send_xform(input xform_t t);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		pos_x <= t.pos[0];
		pos_y <= t.pos[1];
		pos_z <= t.pos[2];
		rot_x <= t.rot[0];
		rot_y <= t.rot[1];
		rot_z <= t.rot[2];
		scale_x <= t.scl[0];
		scale_y <= t.scl[1];
		scale_z <= t.scl[2];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_matrix(t);
		items_sent++;
	endtask

	// lower start and wait for every row to come back
	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_order(input logic [1:0] code);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (code <= mmc_pkg::MODE_STR)
			order_mode = code;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic xform_t make_xform(input int px, py, pz, rx, ry, rz, sx, sy, sz);
		xform_t t;
		t.pos[0] = px; t.pos[1] = py; t.pos[2] = pz;
		t.rot[0] = 16'(rx); t.rot[1] = 16'(ry); t.rot[2] = 16'(rz);
		t.scl[0] = sx; t.scl[1] = sy; t.scl[2] = sz;
		return t;
	endfunction

	// mostly plausible transforms, some with fully random fields
	function automatic xform_t random_xform;
		xform_t t;
		bit wide;
		wide = $urandom_range(0, 9) < 3;
		for (int i = 0; i < 3; i++) begin
			t.rot[i] = 16'($urandom_range(0, 2 * TURN) - TURN);
			if (wide) begin
				t.pos[i] = $urandom;
				t.scl[i] = $urandom;
			end else begin
				t.pos[i] = int'($urandom_range(0, 131072000)) - 65536000;
				t.scl[i] = int'($urandom_range(0, 524288)) - 262144;
			end
		end
		return t;
	endfunction

	// special angles, field extremes and saturation under one order
	task automatic test_directed_angles;
		int angs [12] = '{0, 2880, 2881, 2879, 5760, 11520, 17280, 23040, -23040,
			-1, 1, -2881};
		for (int i = 0; i < 12; i++)
			send_xform(make_xform(65536, -65536, 0, angs[i], angs[(i + 4) % 12],
				angs[(i + 8) % 12], 65536, 65536, 65536));
		send_xform(make_xform(32'h7fffffff, 32'h80000000, 32'h7fffffff, 23040, -23040,
			5760, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_xform(make_xform(32'h80000000, 32'h7fffffff, 32'h80000000, -5760, 2880,
			-11520, 32'h80000000, 32'h7fffffff, 32'h80000000));
		send_xform(make_xform(-1, 1, 0, 0, 0, 0, -1, 0, 1));
		// angles beyond one turn wrap
		send_xform(make_xform(65536, 65536, 65536, 32767, -32768, 30000, 65536,
			-65536, 65536));
	endtask

	// every order code, the rejected code keeps the previous one
	task automatic test_order_codes;
		logic [1:0] codes [4] = '{mmc_pkg::MODE_RTS, mmc_pkg::MODE_STR, MODE_BAD,
			mmc_pkg::MODE_TRS};
		for (int i = 0; i < 4; i++) begin
			write_order(codes[i]);
			send_xform(make_xform(32'h7fffffff, -65536, 3 << 16, 2000, -7000, 12345,
				32'h7fffffff, 32'h80000000, 2 << 16));
			send_xform(make_xform(100 << 16, 32'h80000000, -(5 << 16), -3000, 9000,
				-20000, -(3 << 15), 1 << 16, 32'h7fffffff));
		end
	endtask

	task automatic test_random_traffic(input int pct);
		logic [1:0] codes [3] = '{mmc_pkg::MODE_TRS, mmc_pkg::MODE_RTS, mmc_pkg::MODE_STR};
		idle_pct = pct;
		for (int m = 0; m < 3; m++) begin
			write_order(codes[m]);
			for (int n = 0; n < 50; n++)
				send_xform(random_xform());
		end
	endtask

	initial begin
		#3ms;
		$display("timeout waiting for rows");
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		rot_x = '0; rot_y = '0; rot_z = '0;
		scale_x = '0; scale_y = '0; scale_z = '0;
		order_mode = mmc_pkg::MODE_TRS;
		mismatches = 0;
		items_sent = 0;
		rows_checked = 0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_angles();
		test_order_codes();
		test_random_traffic(15);
		test_random_traffic(69);
		test_random_traffic(0);
		drain();

		$display("covered %0d transforms and %0d rows over all three orders,", items_sent,
			rows_checked);
		$display("with angle folds, wraps, saturation and a rejected order code");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
